/* sv/output_restricted_deque_defines.svh */
// Assertion macros for the output-restricted deque RTL.
// No dependencies; expects clock and reset in the scope of each use.
`ifndef OUTPUT_RESTRICTED_DEQUE_DEFINES_SVH
`define OUTPUT_RESTRICTED_DEQUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ORD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define ORD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ORD_ASSERT_IMP(label, ante, cons, msg)
`define ORD_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

/* sv/ord_pkg.sv */
// Shared types and constants for the output-restricted deque.
// No dependencies; used by ord_ctrl, ord_datapath and the top level.
package ord_pkg;

   localparam int DepthDefault = 128;
   localparam int CapW = 8;
   localparam logic [CapW-1:0] CapReset = 8'd128;
   localparam int WordW = 32;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_REPORT     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic load;
   } cmd_type;

endpackage

/* sv/output_restricted_deque.sv */
// Output-restricted deque of signed 32-bit words in a circular slot memory.
// Depends on ord_pkg, ord_ctrl and ord_datapath.
//
// Request channel: an operation and a word are taken at a rising edge with
// start high and busy low. Operations: insert at front, insert at rear,
// delete front, report only. Inserts into a full deque return overflow,
// deletes from an empty deque return underflow; neither changes state.
// Response channel: rsp_strobe is high for one cycle with the front and rear
// words (zero and not valid when empty), the empty and full flags and the
// status. The receiver cannot stall; the response must be taken that cycle.
// Sequence: after the accepting edge, the execute state performs the pointer
// update and slot write, the load state reads both ends from the slot memory,
// then the strobe is raised. busy falls with the strobe, so a new request may
// be accepted at the edge that ends the strobe cycle; no new request is taken
// while the previous one is still executing or loading.
// Configuration: csr_we writes the capacity (0 acts as 1, above DEPTH acts
// as DEPTH) and empties the deque. Write only while busy is low.
// Reset: capacity 128, deque empty; slot contents are undefined until written.
module output_restricted_deque #(
   parameter int DEPTH = ord_pkg::DepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_operation,
   input  logic signed [ord_pkg::WordW-1:0]  req_value,
   output logic                              rsp_strobe,
   output logic signed [ord_pkg::WordW-1:0]  rsp_front_value,
   output logic                              rsp_front_valid,
   output logic signed [ord_pkg::WordW-1:0]  rsp_rear_value,
   output logic                              rsp_rear_valid,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_we,
   input  logic [ord_pkg::CapW-1:0]          csr_wdata
);

   ord_pkg::cmd_type cmd;

   ord_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   ord_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_front_value (rsp_front_value),
      .rsp_front_valid (rsp_front_valid),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_rear_valid  (rsp_rear_valid),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_status      (rsp_status)
   );

endmodule

/* sv/ord_ctrl.sv */
// Request sequencer for the output-restricted deque.
// Depends on ord_pkg and output_restricted_deque_defines.svh.
`include "output_restricted_deque_defines.svh"

module ord_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_strobe,
   output ord_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               strobe_ff <= 1'b0;
               if (start) begin
                  state_ff <= ST_EXEC;
                  busy_ff  <= 1'b1;
               end
            end
            ST_EXEC: begin
               state_ff  <= ST_LOAD;
               strobe_ff <= 1'b0;
            end
            ST_LOAD: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b1;
            end
            default: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b0;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign cmd.latch  = start && !busy_ff;
   assign cmd.exec   = (state_ff == ST_EXEC);
   assign cmd.load   = (state_ff == ST_LOAD);

   `ORD_ASSERT_NXT(a_accept_busy, cmd.latch, busy && cmd.exec, "accept did not start execution")
   `ORD_ASSERT_NXT(a_load_strobe, cmd.load, rsp_strobe && !busy, "load not followed by response")
   `ORD_ASSERT_IMP(a_strobe_idle, rsp_strobe, !cmd.exec && !cmd.load, "response while working")

endmodule

/* sv/ord_datapath.sv */
// Pointers, capacity register and slot memory of the output-restricted deque.
// Depends on ord_pkg and output_restricted_deque_defines.svh.
`include "output_restricted_deque_defines.svh"

module ord_datapath #(
   parameter int DEPTH = ord_pkg::DepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ord_pkg::cmd_type                  cmd,
   input  logic [1:0]                        req_operation,
   input  logic signed [ord_pkg::WordW-1:0]  req_value,
   input  logic                              csr_we,
   input  logic [ord_pkg::CapW-1:0]          csr_wdata,
   output logic signed [ord_pkg::WordW-1:0]  rsp_front_value,
   output logic                              rsp_front_valid,
   output logic signed [ord_pkg::WordW-1:0]  rsp_rear_value,
   output logic                              rsp_rear_valid,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic [1:0]                        rsp_status
);

   localparam int IdxW = $clog2(DEPTH);

   logic [ord_pkg::WordW-1:0] mem [DEPTH];

   ord_pkg::op_type           op_ff;
   logic [ord_pkg::WordW-1:0] value_ff;
   logic [ord_pkg::CapW-1:0]  capacity_ff;
   logic [IdxW-1:0]           head_ff, head_in;
   logic [IdxW-1:0]           tail_ff, tail_in;
   logic                      empty_ff, empty_in;
   ord_pkg::status_type       status_ff, status_in;
   logic [ord_pkg::WordW-1:0] front_ff, rear_ff;
   logic                      out_empty_ff, out_full_ff;
   logic                      wr_en;
   logic [IdxW-1:0]           wr_addr;
   logic [IdxW-1:0]           cap_m1;
   logic [31:0]               cap_ext;
   logic                      full;
   logic                      is_insert;

   assign cap_ext = 32'(capacity_ff);

   always_comb begin
      priority if (capacity_ff == '0) begin
         cap_m1 = '0;
      end else if (cap_ext > 32'(DEPTH)) begin
         cap_m1 = IdxW'(DEPTH - 1);
      end else begin
         cap_m1 = IdxW'(cap_ext - 32'd1);
      end
   end

   assign full = !empty_ff &&
                 ((head_ff == '0 && tail_ff == cap_m1) ||
                  ({1'b0, head_ff} == ({1'b0, tail_ff} + (IdxW+1)'(1))));

   assign is_insert = (op_ff == ord_pkg::OP_PUSH_FRONT) || (op_ff == ord_pkg::OP_PUSH_REAR);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      status_in = ord_pkg::STAT_DONE;
      wr_en     = 1'b0;
      wr_addr   = '0;
      unique case (op_ff)
         ord_pkg::OP_PUSH_FRONT, ord_pkg::OP_PUSH_REAR: begin
            priority if (full) begin
               status_in = ord_pkg::STAT_OVERFLOW;
            end else if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               wr_en    = 1'b1;
               wr_addr  = '0;
            end else if (op_ff == ord_pkg::OP_PUSH_FRONT) begin
               head_in = (head_ff == '0) ? cap_m1 : head_ff - IdxW'(1);
               wr_en   = 1'b1;
               wr_addr = head_in;
            end else begin
               tail_in = (tail_ff == cap_m1) ? '0 : tail_ff + IdxW'(1);
               wr_en   = 1'b1;
               wr_addr = tail_in;
            end
         end
         ord_pkg::OP_POP_FRONT: begin
            priority if (empty_ff) begin
               status_in = ord_pkg::STAT_UNDERFLOW;
            end else if (head_ff == tail_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
            end else begin
               head_in = (head_ff == cap_m1) ? '0 : head_ff + IdxW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // hold the request payload
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= ord_pkg::op_type'(req_operation);
         value_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= ord_pkg::CapReset;
         head_ff     <= '0;
         tail_ff     <= '0;
         empty_ff    <= 1'b1;
         status_ff   <= ord_pkg::STAT_DONE;
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
         head_ff     <= '0;
         tail_ff     <= '0;
         empty_ff    <= 1'b1;
      end else if (cmd.exec) begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         empty_ff  <= empty_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (cmd.load) begin
         front_ff     <= mem[head_ff];
         rear_ff      <= mem[tail_ff];
         out_empty_ff <= empty_ff;
         out_full_ff  <= full;
      end
   end

   assign rsp_front_value = out_empty_ff ? '0 : front_ff;
   assign rsp_rear_value  = out_empty_ff ? '0 : rear_ff;
   assign rsp_front_valid = !out_empty_ff;
   assign rsp_rear_valid  = !out_empty_ff;
   assign rsp_is_empty    = out_empty_ff;
   assign rsp_is_full     = out_full_ff;
   assign rsp_status      = status_ff;

   `ORD_ASSERT_IMP(a_empty_ptrs, empty_ff, head_ff == '0 && tail_ff == '0, "empty with pointers")
   `ORD_ASSERT_IMP(a_ptr_range, 1'b1, head_ff <= cap_m1 && tail_ff <= cap_m1, "pointer past cap")
   `ORD_ASSERT_NXT(a_overflow_hold, cmd.exec && !csr_we && is_insert && full,
      $stable(head_ff) && $stable(tail_ff) && !empty_ff, "refused insert moved pointers")

endmodule
